@@ rtl/core/thup_pkg.sv @@
package thup_pkg;

  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 34;

  localparam int SAMPLE_W  = 16;
  localparam int INDEX_W   = 10;
  localparam int FADDR_W   = 15;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int SCALE_W   = 24;
  localparam int PALETTE_W = 8;

  localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [1:0] REG_NORM_SCALE = 2'd2;

  typedef struct packed {
    logic prod_en;
    logic acc_en;
    logic acc_clr;
  } mac_ctrl_t;

endpackage

@@ rtl/core/thermal_upscale_palette_index_core.sv @@
// Thermal frame upscaler with palette index output.
// The input channel (in_valid/in_ready) carries one beat per item. A beat with
// opcode 0 stores sample_value at sample_index and updates the running maximum
// and minimum; index 0 starts a new frame. A beat with opcode 1 renders the
// output pixel at pixel_x, pixel_y by bilinear interpolation of four samples.
// The output channel (out_valid/out_ready) returns one beat per input beat with
// the interpolated temperature, the palette index, the mirrored frame address
// and the running statistics. Load results carry zero in the pixel fields.
// A pixel steps through the sequencer states from acceptance to its result,
// all of them on the one shared multiply-accumulate unit, and a new item (load
// or pixel) is taken only once the current one has reached the output register.
// The result waits in an output register; while the receiver stalls, the next
// item is still accepted and processed, and the block holds it in its last
// step until the output register frees up.
// Reset clears the sequencer, the statistics and the configuration registers
// to their defaults. The sample store is not cleared; render pixels only from
// samples that were loaded. Configuration is written over the APB port.
module thermal_upscale_palette_index_core import thup_pkg::*; #(
  parameter int SRC_COLS = 32,
  parameter int SRC_ROWS = 24,
  parameter int DST_COLS = 187,
  parameter int DST_ROWS = 119
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       opcode,
  input  logic [INDEX_W-1:0]         sample_index,
  input  logic signed [SAMPLE_W-1:0] sample_value,
  input  logic [7:0]                 pixel_x,
  input  logic [6:0]                 pixel_y,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] pixel_temp,
  output logic [PALETTE_W-1:0]       palette_index,
  output logic [FADDR_W-1:0]         frame_address,
  output logic signed [SAMPLE_W-1:0] max_value,
  output logic [INDEX_W-1:0]         max_position,
  output logic signed [SAMPLE_W-1:0] min_value,
  output logic [INDEX_W-1:0]         min_position
);

  localparam int DEPTH = SRC_COLS * SRC_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(SRC_COLS);
  localparam int RW    = $clog2(SRC_ROWS);
  localparam int XW    = $clog2(DST_COLS);
  localparam int YW    = $clog2(DST_ROWS);
  localparam int XSTEP = ((SRC_COLS * 65536) + (DST_COLS / 2)) / DST_COLS;
  localparam int YSTEP = ((SRC_ROWS * 65536) + (DST_ROWS / 2)) / DST_ROWS;
  localparam int HI_W  = PROD_W - 16;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_MUL_SX   = 5'd1;
  localparam logic [4:0] ST_MUL_SY   = 5'd2;
  localparam logic [4:0] ST_MUL_ROW  = 5'd3;
  localparam logic [4:0] ST_MUL_BASE = 5'd4;
  localparam logic [4:0] ST_MUL_W00  = 5'd5;
  localparam logic [4:0] ST_MUL_W01  = 5'd6;
  localparam logic [4:0] ST_MUL_W10  = 5'd7;
  localparam logic [4:0] ST_MUL_W11  = 5'd8;
  localparam logic [4:0] ST_MAC00    = 5'd9;
  localparam logic [4:0] ST_MAC01    = 5'd10;
  localparam logic [4:0] ST_MAC10    = 5'd11;
  localparam logic [4:0] ST_MAC11    = 5'd12;
  localparam logic [4:0] ST_ACC_LAST = 5'd13;
  localparam logic [4:0] ST_CLAMP    = 5'd14;
  localparam logic [4:0] ST_MUL_NORM = 5'd15;
  localparam logic [4:0] ST_DONE     = 5'd16;

  logic [4:0] state;
  logic       is_load;

  logic signed [SAMPLE_W-1:0] range_low;
  logic signed [SAMPLE_W-1:0] range_high;
  logic [SCALE_W-1:0]         norm_scale;

  logic signed [SAMPLE_W-1:0] run_max;
  logic signed [SAMPLE_W-1:0] run_min;
  logic [INDEX_W-1:0]         max_idx;
  logic [INDEX_W-1:0]         min_idx;

  logic [XW-1:0]      xs;
  logic [YW-1:0]      ys;
  logic [15:0]        fx;
  logic [15:0]        fy;
  logic [CW-1:0]      cx;
  logic [RW-1:0]      cy;
  logic [AW-1:0]      base;
  logic [FADDR_W-1:0] faddr;
  logic [16:0]        w00;
  logic [16:0]        w01;
  logic [16:0]        w10;
  logic [16:0]        w11;
  logic [16:0]        gx;
  logic [16:0]        gy;

  logic signed [SAMPLE_W-1:0] temp;
  logic signed [17:0]         dreg;
  logic                       dpos;

  logic signed [17:0] temp_full;
  logic signed [17:0] lo_ext;
  logic signed [17:0] hi_ext;
  logic signed [17:0] tc_low;
  logic signed [17:0] tc_both;
  logic signed [17:0] diff;

  mac_ctrl_t                 mac_ctrl;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic [HI_W-1:0]           prod_hi;

  logic                cfg_write;
  logic                in_fire;
  logic                load_ok;
  logic                ram_we;
  logic [AW-1:0]       raddr;
  logic [SAMPLE_W-1:0] rdata;
  logic                out_free;
  logic [PALETTE_W-1:0] pal;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load_ok   = (int'(sample_index) < DEPTH);
  assign ram_we    = in_fire && !opcode && load_ok;
  assign out_free  = !out_valid || out_ready;
  assign gx        = 17'h10000 - {1'b0, fx};
  assign gy        = 17'h10000 - {1'b0, fy};
  assign prod_hi   = prod[PROD_W-1:16];

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_RANGE_LOW:  prdata = {16'd0, range_low};
      REG_RANGE_HIGH: prdata = {16'd0, range_high};
      REG_NORM_SCALE: prdata = {8'd0, norm_scale};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= 16'sd2400;
      range_high <= 16'sd3000;
      norm_scale <= 24'd27852;
    end else if (cfg_write) begin
      case (paddr[PADDR_W-1:2])
        REG_RANGE_LOW:  range_low  <= pwdata[15:0];
        REG_RANGE_HIGH: range_high <= pwdata[15:0];
        REG_NORM_SCALE: norm_scale <= pwdata[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_max <= 16'sh8000;
      run_min <= 16'sh7fff;
      max_idx <= '0;
      min_idx <= '0;
    end else if (ram_we) begin
      if (sample_index == '0) begin
        run_max <= sample_value;
        run_min <= sample_value;
        max_idx <= '0;
        min_idx <= '0;
      end else begin
        if (sample_value > run_max) begin
          run_max <= sample_value;
          max_idx <= sample_index;
        end
        if (sample_value < run_min) begin
          run_min <= sample_value;
          min_idx <= sample_index;
        end
      end
    end
  end

  thup_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(sample_index)),
    .wdata (sample_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    mac_ctrl = '0;
    mul_a    = '0;
    mul_b    = '0;
    raddr    = base;
    case (state)
      ST_MUL_SX: begin
        mac_ctrl.prod_en = 1'b1;
        mul_a = MUL_A_W'(xs);
        mul_b = MUL_B_W'(XSTEP);
      end
      ST_MUL_SY: begin
        mac_ctrl.prod_en = 1'b1;
        mul_a = MUL_A_W'(ys);
        mul_b = MUL_B_W'(YSTEP);
      end
      ST_MUL_ROW: begin
        mac_ctrl.prod_en = 1'b1;
        mul_a = MUL_A_W'(ys);
        mul_b = MUL_B_W'(DST_COLS);
      end
      ST_MUL_BASE: begin
        mac_ctrl.prod_en = 1'b1;
        mul_a = MUL_A_W'(cy);
        mul_b = MUL_B_W'(SRC_COLS);
      end
      ST_MUL_W00: begin
        mac_ctrl.prod_en = 1'b1;
        mul_a = MUL_A_W'(gx);
        mul_b = MUL_B_W'(gy);
      end
      ST_MUL_W01: begin
        mac_ctrl.prod_en = 1'b1;
        mul_a = MUL_A_W'(fx);
        mul_b = MUL_B_W'(gy);
      end
      ST_MUL_W10: begin
        mac_ctrl.prod_en = 1'b1;
        mul_a = MUL_A_W'(gx);
        mul_b = MUL_B_W'(fy);
      end
      ST_MUL_W11: begin
        mac_ctrl.prod_en = 1'b1;
        mul_a = MUL_A_W'(fx);
        mul_b = MUL_B_W'(fy);
        raddr = base;
      end
      ST_MAC00: begin
        mac_ctrl.prod_en = 1'b1;
        mul_a = MUL_A_W'($signed(rdata));
        mul_b = MUL_B_W'(w00);
        raddr = base + AW'(1);
      end
      ST_MAC01: begin
        mac_ctrl.prod_en = 1'b1;
        mac_ctrl.acc_en  = 1'b1;
        mac_ctrl.acc_clr = 1'b1;
        mul_a = MUL_A_W'($signed(rdata));
        mul_b = MUL_B_W'(w01);
        raddr = base + AW'(SRC_COLS);
      end
      ST_MAC10: begin
        mac_ctrl.prod_en = 1'b1;
        mac_ctrl.acc_en  = 1'b1;
        mul_a = MUL_A_W'($signed(rdata));
        mul_b = MUL_B_W'(w10);
        raddr = base + AW'(SRC_COLS + 1);
      end
      ST_MAC11: begin
        mac_ctrl.prod_en = 1'b1;
        mac_ctrl.acc_en  = 1'b1;
        mul_a = MUL_A_W'($signed(rdata));
        mul_b = MUL_B_W'(w11);
      end
      ST_ACC_LAST: begin
        mac_ctrl.acc_en = 1'b1;
      end
      ST_MUL_NORM: begin
        mac_ctrl.prod_en = 1'b1;
        mul_a = dreg;
        mul_b = MUL_B_W'(norm_scale);
      end
      default: begin
      end
    endcase
  end

  thup_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod),
    .acc  (acc)
  );

  always_comb begin
    temp_full = acc[ACC_W-1:16];
    lo_ext    = 18'(range_low);
    hi_ext    = 18'(range_high);
    tc_low    = (temp_full < lo_ext) ? lo_ext : temp_full;
    tc_both   = (tc_low > hi_ext) ? hi_ext : tc_low;
    diff      = tc_both - lo_ext;
  end

  always_comb begin
    if (!dpos) begin
      pal = '0;
    end else if (prod_hi > HI_W'(255)) begin
      pal = 8'd255;
    end else begin
      pal = prod_hi[PALETTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= opcode ? ST_MUL_SX : ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= state + 5'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          is_load <= !opcode;
          if (int'(pixel_x) > DST_COLS - 1) begin
            xs <= XW'(DST_COLS - 1);
          end else begin
            xs <= XW'(pixel_x);
          end
          if (int'(pixel_y) > DST_ROWS - 1) begin
            ys <= YW'(DST_ROWS - 1);
          end else begin
            ys <= YW'(pixel_y);
          end
        end
      end
      ST_MUL_SY: begin
        fx <= prod[15:0];
        if (prod_hi > HI_W'(SRC_COLS - 2)) begin
          cx <= CW'(SRC_COLS - 2);
        end else begin
          cx <= prod_hi[CW-1:0];
        end
      end
      ST_MUL_ROW: begin
        fy <= prod[15:0];
        if (prod_hi > HI_W'(SRC_ROWS - 2)) begin
          cy <= RW'(SRC_ROWS - 2);
        end else begin
          cy <= prod_hi[RW-1:0];
        end
      end
      ST_MUL_BASE: begin
        faddr <= prod[FADDR_W-1:0] + FADDR_W'(DST_COLS - 1) - FADDR_W'(xs);
      end
      ST_MUL_W00: begin
        base <= prod[AW-1:0] + AW'(cx);
      end
      ST_MUL_W01: begin
        w00 <= prod[32:16];
      end
      ST_MUL_W10: begin
        w01 <= prod[32:16];
      end
      ST_MUL_W11: begin
        w10 <= prod[32:16];
      end
      ST_MAC00: begin
        w11 <= prod[32:16];
      end
      ST_CLAMP: begin
        temp <= temp_full[SAMPLE_W-1:0];
        dreg <= diff;
        dpos <= (diff > 18'sd0);
      end
      ST_DONE: begin
        if (out_free) begin
          pixel_temp    <= is_load ? '0 : temp;
          palette_index <= is_load ? '0 : pal;
          frame_address <= is_load ? '0 : faddr;
          max_value     <= run_max;
          max_position  <= max_idx;
          min_value     <= run_min;
          min_position  <= min_idx;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/thup_ram.sv @@
module thup_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/thup_mac.sv @@
module thup_mac import thup_pkg::*; (
  input  logic                      clk,
  input  mac_ctrl_t                 ctrl,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod,
  output logic signed [ACC_W-1:0]   acc
);

  logic signed [ACC_W-1:0] acc_base;

  assign acc_base = ctrl.acc_clr ? '0 : acc;

  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod <= a * b;
    end
    if (ctrl.acc_en) begin
      acc <= acc_base + $signed(prod[ACC_W-1:0]);
    end
  end

endmodule
